[src/swcs_pkg.sv]
// Shared constants, register codes and control structs for the chi-square monitor.
`timescale 1ns / 1ps

package swcs_pkg;

  localparam int WINDOW_MAX_DEF = 4096;
  localparam int BINS_DEF       = 100;

  localparam int SAMPLE_W   = 7;
  localparam int WIN_W      = 13;
  localparam int THR_W      = 19;
  localparam int CHI_W      = 19;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 19;

  localparam logic [WIN_W-1:0] WIN_RESET = 13'd1000;
  localparam logic [THR_W-1:0] THR_RESET = 19'd124;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'b1;

  typedef struct packed {
    logic latch;
    logic mul;
    logic div_step;
    logic chi;
    logic emit;
    logic rm_rd;
    logic rm_wr;
    logic add_rd;
    logic add_wr;
  } swcs_cmd_t;

  typedef struct packed {
    logic sample_ok;
    logic full;
    logic div_last;
    logic out_free;
  } swcs_status_t;

endpackage

[src/swcs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module swcs_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/swcs_ctrl.sv]
// Controller state machine sequencing fill, divide, emit and histogram update.
`timescale 1ns / 1ps

module swcs_ctrl
  import swcs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  swcs_status_t status,
  output swcs_cmd_t    cmd,
  output logic         in_stall,
  output logic         cfg_ready
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_CHI    = 4'd3;
  localparam logic [3:0] S_EMIT   = 4'd4;
  localparam logic [3:0] S_RM_RD  = 4'd5;
  localparam logic [3:0] S_RM_WR  = 4'd6;
  localparam logic [3:0] S_ADD_RD = 4'd7;
  localparam logic [3:0] S_ADD_WR = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && status.sample_ok) begin
          state_next = status.full ? S_MUL : S_ADD_RD;
        end
      end
      S_MUL:    state_next = S_DIV;
      S_DIV:    if (status.div_last) state_next = S_CHI;
      S_CHI:    state_next = S_EMIT;
      S_EMIT:   if (status.out_free) state_next = S_RM_RD;
      S_RM_RD:  state_next = S_RM_WR;
      S_RM_WR:  state_next = S_ADD_RD;
      S_ADD_RD: state_next = S_ADD_WR;
      S_ADD_WR: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = rst || (state != S_IDLE);
  assign cfg_ready = !rst && (state == S_IDLE) && !in_valid;

  always_comb begin
    cmd          = '0;
    cmd.latch    = (state == S_IDLE) && in_valid;
    cmd.mul      = (state == S_MUL);
    cmd.div_step = (state == S_DIV);
    cmd.chi      = (state == S_CHI);
    cmd.emit     = (state == S_EMIT) && status.out_free;
    cmd.rm_rd    = (state == S_RM_RD);
    cmd.rm_wr    = (state == S_RM_WR);
    cmd.add_rd   = (state == S_ADD_RD);
    cmd.add_wr   = (state == S_ADD_WR);
  end

endmodule

[src/swcs_dp.sv]
// Datapath: config registers, sample ring, histogram, serial divider and output register.
`timescale 1ns / 1ps

module swcs_dp
  import swcs_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int BINS       = BINS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  swcs_cmd_t             cmd,
  output swcs_status_t          status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [SAMPLE_W-1:0]   sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHI_W-1:0]      chi_square,
  output logic                  is_random
);

  localparam int AW  = $clog2(WINDOW_MAX);
  localparam int NW  = $clog2(WINDOW_MAX + 1);
  localparam int BW  = $clog2(BINS);
  localparam int SW  = 2 * NW;
  localparam int QW  = SW + $clog2(BINS + 1);
  localparam int KW  = $clog2(QW);

  logic [WIN_W-1:0]    win_len;
  logic [THR_W-1:0]    thr;
  logic [NW-1:0]       n;
  logic [NW-1:0]       fill;
  logic [AW-1:0]       ptr;
  logic [NW-1:0]       ptr_inc;
  logic [SW-1:0]       sos;
  logic [SAMPLE_W-1:0] sample_r;
  logic [BINS-1:0]     bin_vld;

  logic [QW-1:0]       q;
  logic [NW-1:0]       rem;
  logic [NW:0]         rem_sh;
  logic                ge;
  logic [KW-1:0]       cnt;
  logic [QW-1:0]       chi_r;

  logic [SAMPLE_W-1:0] ring_rdata;
  logic [BW-1:0]       old_bin;
  logic [BW-1:0]       new_bin;
  logic [BW-1:0]       bin_raddr;
  logic [BW-1:0]       bin_addr_q;
  logic                bin_vld_q;
  logic [NW-1:0]       bin_rdata;
  logic [NW-1:0]       cnt_cur;
  logic [NW-1:0]       cnt_dec;
  logic                bin_we;
  logic [NW-1:0]       bin_wdata;

  always_comb begin
    if (win_len == '0) begin
      n = NW'(1);
    end else if (32'(win_len) > WINDOW_MAX) begin
      n = NW'(WINDOW_MAX);
    end else begin
      n = NW'(win_len);
    end
  end

  assign old_bin   = BW'(ring_rdata);
  assign new_bin   = BW'(sample_r);
  assign bin_raddr = cmd.rm_rd ? old_bin : new_bin;
  assign cnt_cur   = bin_vld_q ? bin_rdata : '0;
  assign cnt_dec   = cnt_cur - NW'(1);
  assign ptr_inc   = NW'(ptr) + NW'(1);

  always_comb begin
    bin_we    = 1'b0;
    bin_wdata = cnt_cur + NW'(1);
    if (cmd.rm_wr) begin
      bin_we    = (cnt_cur != '0);
      bin_wdata = cnt_dec;
    end else if (cmd.add_wr) begin
      bin_we    = 1'b1;
    end
  end

  swcs_ram #(.W(SAMPLE_W), .D(WINDOW_MAX)) u_ring (
    .clk   (clk),
    .we    (cmd.add_wr),
    .waddr (ptr),
    .wdata (sample_r),
    .raddr (ptr),
    .rdata (ring_rdata)
  );

  swcs_ram #(.W(NW), .D(BINS)) u_bins (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_addr_q),
    .wdata (bin_wdata),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  assign rem_sh = {rem, q[QW-1]};
  assign ge     = (rem_sh >= {1'b0, n});

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len <= WIN_RESET;
      thr     <= THR_RESET;
      fill    <= '0;
      ptr     <= '0;
      sos     <= '0;
      bin_vld <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_LEN: begin
            win_len <= cfg_data[WIN_W-1:0];
            fill    <= '0;
            ptr     <= '0;
            sos     <= '0;
            bin_vld <= '0;
          end
          REG_THRESHOLD: thr <= cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.rm_wr && cnt_cur != '0) begin
        sos <= sos - SW'({cnt_dec, 1'b1});
      end
      if (cmd.add_wr) begin
        sos                 <= sos + SW'({cnt_cur, 1'b1});
        bin_vld[bin_addr_q] <= 1'b1;
        ptr                 <= (ptr_inc >= n) ? '0 : AW'(ptr_inc);
        if (fill < n) begin
          fill <= fill + NW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sample_r <= sample;
    end
    if (cmd.rm_rd || cmd.add_rd) begin
      bin_addr_q <= bin_raddr;
      bin_vld_q  <= bin_vld[bin_raddr];
    end
    if (cmd.mul) begin
      q   <= QW'(sos) * QW'(BINS);
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      q   <= {q[QW-2:0], ge};
      rem <= ge ? NW'(rem_sh - {1'b0, n}) : NW'(rem_sh);
      cnt <= cnt + KW'(1);
    end
    if (cmd.chi) begin
      chi_r <= (q >= QW'(n)) ? q - QW'(n) : '0;
    end
    if (cmd.emit) begin
      chi_square <= CHI_W'(chi_r);
      is_random  <= (chi_r < QW'(thr));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.sample_ok = (32'(sample) < BINS);
  assign status.full      = (fill == n);
  assign status.div_last  = (cnt == KW'(QW - 1));
  assign status.out_free  = !out_valid || !out_stall;

endmodule

[src/sliding_window_chi_square_monitor.sv]
// Top level of the sliding-window chi-square monitor.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    sample
//   result    out        out_valid / out_stall  chi_square, is_random
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A sample taken while the window fills runs ADD_RD, ADD_WR; an out-of-range one is dropped.
// A full-window sample runs MUL, DIV, CHI, EMIT, RM_RD, RM_WR, ADD_RD and ADD_WR;
// DIV yields one bit per cycle over QW = 2*clog2(WINDOW_MAX+1) + clog2(BINS+1) bits.
// Reset and window_len writes clear the histogram at once through per-bin valid bits.
// A stalled result holds the controller before the histogram update; one result may
// wait while the next sample is accepted.
`timescale 1ns / 1ps

module sliding_window_chi_square_monitor
  import swcs_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int BINS       = BINS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHI_W-1:0]      chi_square,
  output logic                  is_random,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  swcs_cmd_t    cmd;
  swcs_status_t status;

  swcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready)
  );

  swcs_dp #(.WINDOW_MAX(WINDOW_MAX), .BINS(BINS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .chi_square (chi_square),
    .is_random  (is_random)
  );

endmodule

[src/swcs_chk.sv]
// Port-level checker for the chi-square monitor, bound to the top level.
`timescale 1ns / 1ps

module swcs_chk
  import swcs_pkg::*;
#(
  parameter int BINS = BINS_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic [SAMPLE_W-1:0] sample,
  input logic                out_valid,
  input logic                out_stall,
  input logic [CHI_W-1:0]    chi_square,
  input logic                is_random,
  input logic                cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(chi_square) && $stable(is_random))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (32'(sample) < BINS) |=> in_stall)
    else $error("in-range sample did not start processing");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !in_stall)
    else $error("config ready outside idle");

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_stall)
    else $error("result appeared without a transaction in progress");

endmodule

bind sliding_window_chi_square_monitor swcs_chk #(.BINS(BINS)) u_chk (.*);

[dv/sliding_window_chi_square_checker.sv]
// Checker for the chi-square monitor: tracks the sliding window and compares every result.
`timescale 1ns / 1ps

module sliding_window_chi_square_checker
  import swcs_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int BINS       = BINS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   sample,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [CHI_W-1:0]      chi_square,
  input  logic                  is_random,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending,
  output int                    results
);

  logic [WIN_W-1:0]              win_reg;
  logic [THR_W-1:0]              thr_reg;
  logic [SAMPLE_W-1:0]           ring [WINDOW_MAX];
  logic [WIN_W-1:0]              bin_cnt [BINS];
  logic [24:0]                   sq_sum;
  logic [WIN_W-1:0]              fill;
  logic [$clog2(WINDOW_MAX)-1:0] slot;

  logic [CHI_W-1:0] chi_due[$];
  logic             verdict_due[$];
  logic [CHI_W-1:0] want_chi;
  logic             want_verdict;
  int               n_err = 0;
  int               n_res = 0;

  function automatic int window_size();
    if (win_reg == '0) return 1;
    if (win_reg > WINDOW_MAX) return WINDOW_MAX;
    return int'(win_reg);
  endfunction

  function automatic void clear_window();
    foreach (bin_cnt[i]) bin_cnt[i] = '0;
    sq_sum = '0;
    fill   = '0;
    slot   = '0;
  endfunction

  function automatic void bin_inc(int b);
    sq_sum     = sq_sum + 25'(2 * int'(bin_cnt[b]) + 1);
    bin_cnt[b] = bin_cnt[b] + 1'b1;
  endfunction

  function automatic void bin_dec(int b);
    if (bin_cnt[b] == '0) return;
    bin_cnt[b] = bin_cnt[b] - 1'b1;
    sq_sum     = sq_sum - 25'(2 * int'(bin_cnt[b]) + 1);
  endfunction

  function automatic void window_take(logic [SAMPLE_W-1:0] s);
    int     n;
    longint q;
    longint chi;
    logic   verdict;
    n = window_size();
    if (int'(s) >= BINS) return;
    if (int'(slot) >= n) slot = '0;
    if (int'(fill) < n) begin
      ring[slot] = s;
      bin_inc(int'(s));
      fill = fill + 1'b1;
      slot = (int'(slot) + 1 >= n) ? '0 : slot + 1'b1;
      return;
    end
    q       = (longint'(BINS) * longint'(sq_sum)) / n;
    chi     = (q >= n) ? q - n : 0;
    verdict = (chi < longint'(thr_reg));
    chi_due.insert(chi_due.size(), CHI_W'(chi));
    verdict_due.insert(verdict_due.size(), verdict);
    bin_dec(int'(ring[slot]) % BINS);
    ring[slot] = s;
    bin_inc(int'(s));
    slot = (int'(slot) + 1 >= n) ? '0 : slot + 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      win_reg = WIN_RESET;
      thr_reg = THR_RESET;
      clear_window();
      chi_due.delete();
      verdict_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WINDOW_LEN) begin
          win_reg = cfg_data[WIN_W-1:0];
          clear_window();
        end else if (cfg_index == REG_THRESHOLD) begin
          thr_reg = cfg_data[THR_W-1:0];
        end
      end
      if (out_valid && !out_stall) begin
        n_res++;
        if (chi_due.size() == 0) begin
          $error("unexpected result: chi_square %0d is_random %0b", chi_square, is_random);
          n_err++;
        end else begin
          want_chi     = chi_due.pop_front();
          want_verdict = verdict_due.pop_front();
          if (chi_square !== want_chi) begin
            $error("chi_square mismatch: expected %0d, got %0d", want_chi, chi_square);
            n_err++;
          end
          if (is_random !== want_verdict) begin
            $error("is_random mismatch: expected %0b, got %0b", want_verdict, is_random);
            n_err++;
          end
        end
      end
      if (in_valid && !in_stall) window_take(sample);
    end
    errors  <= n_err;
    pending <= chi_due.size();
    results <= n_res;
  end

endmodule

[dv/sliding_window_chi_square_monitor_tb.sv]
// Testbench top for the chi-square monitor: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module sliding_window_chi_square_monitor_tb;
  import swcs_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   sample    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHI_W-1:0]      chi_square;
  logic                  is_random;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_WINDOW_LEN;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic calm     = 1'b0;
  logic hold     = 1'b0;
  logic press_go = 1'b0;

  int errors;
  int pending;
  int results;
  int n_valid   = 0;
  int n_ignored = 0;
  int n_writes  = 0;
  int cur_len   = int'(WIN_RESET);
  bit win_clear = 1'b1;

  sliding_window_chi_square_monitor uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .chi_square (chi_square),
    .is_random  (is_random),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sliding_window_chi_square_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .chi_square (chi_square),
    .is_random  (is_random),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending),
    .results    (results)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= hold || (!calm && $urandom_range(99) < 21);
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (press_go);
    @(posedge clk);
    hold <= 1'b1;
    repeat (400) @(posedge clk);
    hold <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int eff_len(logic [CFG_DATA_W-1:0] d);
    logic [WIN_W-1:0] v;
    v = d[WIN_W-1:0];
    if (v == '0) return 1;
    if (v > WINDOW_MAX_DEF) return WINDOW_MAX_DEF;
    return int'(v);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(int mode, int base, int spread);
    int v;
    if ($urandom_range(99) < 8) return SAMPLE_W'($urandom_range(127, BINS_DEF));
    case (mode)
      0: v = $urandom_range(BINS_DEF - 1);
      1: v = base + $urandom_range(spread);
      default: v = ($urandom_range(3) == 0) ? $urandom_range(BINS_DEF - 1) : base;
    endcase
    if (v > BINS_DEF - 1) v = BINS_DEF - 1;
    return SAMPLE_W'(v);
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (in_stall);
    if (s >= BINS_DEF) n_ignored++;
    else n_valid++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    n_writes++;
  endtask

  // drain all results and let the block go idle before touching registers
  task automatic configure(input bit set_win, input logic [CFG_DATA_W-1:0] win_data,
                           input bit set_thr, input logic [CFG_DATA_W-1:0] thr_data);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (64) @(posedge clk);
    if (set_win) begin
      write_reg(REG_WINDOW_LEN, win_data);
      cur_len   = eff_len(win_data);
      win_clear = 1'b1;
    end
    if (set_thr) write_reg(REG_THRESHOLD, thr_data);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_window(input int want, input int mode, input int base, input int spread);
    int need;
    int got;
    logic [SAMPLE_W-1:0] s;
    need      = (win_clear ? cur_len : 0) + want;
    win_clear = 1'b0;
    got       = 0;
    while (got < need) begin
      s = pick_sample(mode, base, spread);
      send_sample(s);
      if (s < BINS_DEF) got++;
    end
  endtask

  initial begin : stimulus
    int                    n;
    int                    phase;
    int                    stop_at;
    int                    w;
    bit                    set_win;
    logic [CFG_DATA_W-1:0] win_data;
    logic [CFG_DATA_W-1:0] thr_data;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: window of 1000 only starts to fill
    repeat (20) send_sample(pick_sample(0, 0, 0));

    // zero length acts as one; threshold boundary at the only possible value
    configure(1'b1, '0, 1'b1, 19'd100);
    send_sample(7'd0);
    send_sample(7'd99);
    send_sample(7'd100);
    send_sample(7'd127);
    send_sample(7'd64);
    configure(1'b0, '0, 1'b1, 19'd99);
    send_sample(7'd99);
    send_sample(7'd1);

    // upper data bits drop out of the length; zero threshold
    configure(1'b1, 19'h7E002, 1'b1, '0);
    send_sample(7'd5);
    send_sample(7'd5);
    send_sample(7'd5);
    send_sample(7'd7);
    send_sample(7'd9);
    send_sample(7'd9);
    configure(1'b0, '0, 1'b1, 19'h7FFFF);
    send_sample(7'd0);
    send_sample(7'd99);

    // oversize length saturates; the window only starts to fill
    configure(1'b1, 19'h01FFF, 1'b1, 19'd405504);
    repeat (12) send_sample(pick_sample(0, 0, 0));

    stop_at = 1650;
    phase   = 0;
    while (n_valid + n_ignored < stop_at) begin
      phase++;
      calm <= (phase == 3 || phase == 4);
      set_win = (phase <= 3) || ($urandom_range(3) != 0);
      case ($urandom_range(19))
        0: n = 0;
        1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: n = $urandom_range(40, 1);
        default: n = $urandom_range(160, 41);
      endcase
      if (phase == 3) n = 3;
      win_data = {6'($urandom), 13'(n)};
      w = set_win ? eff_len(win_data) : cur_len;
      case ($urandom_range(9))
        0: thr_data = '0;
        1: thr_data = 19'h7FFFF;
        2: thr_data = 19'($urandom);
        3, 4, 5: thr_data = 19'($urandom_range(300));
        default: thr_data = 19'($urandom_range(99 * w));
      endcase
      configure(set_win, win_data, 1'b1, thr_data);
      if (phase == 3) press_go <= 1'b1;
      run_window((phase == 3) ? 60 : $urandom_range(60, 20), $urandom_range(2),
                 $urandom_range(BINS_DEF - 1), $urandom_range(30));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    for (w = 0; w < 20000 && pending != 0; w++) @(posedge clk);
    repeat (64) @(posedge clk);
    if (pending != 0) $error("%0d expected results never arrived", pending);

    $display("Checked %0d results from %0d in-range and %0d out-of-range samples, %0d writes.",
             results, n_valid, n_ignored, n_writes);
    $display("Windows 1 to 160 plus zero and oversize lengths, thresholds 0 to full scale.");
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/swcs_pkg.sv
src/swcs_ram.sv
src/swcs_ctrl.sv
src/swcs_dp.sv
src/sliding_window_chi_square_monitor.sv
src/swcs_chk.sv
dv/sliding_window_chi_square_checker.sv
dv/sliding_window_chi_square_monitor_tb.sv
